// File: src/wcp_pkg.sv
// ----------------------------------------------------------------------------
// wcp_pkg
// Shared types and constants of the WAV chunk parser: result codes, chunk
// tags and the command record that runs from the parser to the output stage.
// ----------------------------------------------------------------------------
package wcp_pkg;

   // result status codes
   localparam logic [2:0] ST_SAMPLE  = 3'd0;
   localparam logic [2:0] ST_FMT_OK  = 3'd1;
   localparam logic [2:0] ST_BAD_TAG = 3'd2;
   localparam logic [2:0] ST_BAD_FMT = 3'd3;
   localparam logic [2:0] ST_NO_FMT  = 3'd4;

   // tags as they sit in the shift register after four little-endian bytes
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [31:0] FMT_BODY = 32'd16;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  sample_byte;
      logic        block_last;
      logic [1:0]  sample_type;
      logic [31:0] frame_rate;
   } wcp_cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } wcp_qstat_type;

endpackage

// File: src/wcp_front.sv
// ----------------------------------------------------------------------------
// wcp_front
// Byte parser: walks the RIFF/WAVE chunk structure one byte per transfer and
// issues a command record for every byte that yields a result.
// ----------------------------------------------------------------------------
module wcp_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         file_byte,
   input  logic               restart,
   output logic               push,
   output wcp_pkg::wcp_cmd_type cmd
);

   localparam logic [3:0] PH_RIFF  = 4'd0;
   localparam logic [3:0] PH_RSIZE = 4'd1;
   localparam logic [3:0] PH_WAVE  = 4'd2;
   localparam logic [3:0] PH_ID    = 4'd3;
   localparam logic [3:0] PH_LEN   = 4'd4;
   localparam logic [3:0] PH_FMT   = 4'd5;
   localparam logic [3:0] PH_SKIP  = 4'd6;
   localparam logic [3:0] PH_DATA  = 4'd7;
   localparam logic [3:0] PH_PAD   = 4'd8;
   localparam logic [3:0] PH_HALT  = 4'd9;

   logic [3:0]  phase_ff, phase_in, c_phase;
   logic [4:0]  count_ff, count_in, c_count;
   logic [31:0] tag_ff, tag_in, c_tag;
   logic [31:0] len_ff, len_in, c_len;
   logic [31:0] left_ff, left_in, c_left;
   logic [15:0] code_ff, code_in, c_code;
   logic [15:0] chan_ff, chan_in, c_chan;
   logic [31:0] rate_ff, rate_in, c_rate;
   logic [15:0] bits_ff, bits_in, c_bits;
   logic [2:0]  bb_ff, bb_in, c_bb;
   logic [1:0]  pos_ff, pos_in, c_pos;
   logic        seen_ff, seen_in, c_seen;

   logic [1:0]  bb_mask;
   logic [1:0]  rem;
   logic        is_stereo, is_16, fmt_ok, last;

   always_comb begin
      // restart clears everything before the byte is parsed
      c_phase = restart ? PH_RIFF : phase_ff;
      c_count = restart ? '0 : count_ff;
      c_tag   = restart ? '0 : tag_ff;
      c_len   = restart ? '0 : len_ff;
      c_left  = restart ? '0 : left_ff;
      c_code  = restart ? '0 : code_ff;
      c_chan  = restart ? '0 : chan_ff;
      c_rate  = restart ? '0 : rate_ff;
      c_bits  = restart ? '0 : bits_ff;
      c_bb    = restart ? '0 : bb_ff;
      c_pos   = restart ? '0 : pos_ff;
      c_seen  = restart ? 1'b0 : seen_ff;

      phase_in = c_phase;
      count_in = c_count;
      tag_in   = c_tag;
      len_in   = c_len;
      left_in  = c_left;
      code_in  = c_code;
      chan_in  = c_chan;
      rate_in  = c_rate;
      bits_in  = c_bits;
      bb_in    = c_bb;
      pos_in   = c_pos;
      seen_in  = c_seen;

      push      = 1'b0;
      cmd       = '0;
      bb_mask   = 2'(c_bb - 3'd1);
      rem       = c_len[1:0] & bb_mask;
      is_stereo = 1'b0;
      is_16     = 1'b0;
      fmt_ok    = 1'b0;
      last      = 1'b0;

      unique case (c_phase) inside
         PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID: begin
            tag_in   = {file_byte, c_tag[31:8]};
            count_in = c_count + 5'd1;
            if (c_count == 5'd3) begin
               count_in = '0;
               unique case (c_phase)
                  PH_RIFF: begin
                     if (tag_in != wcp_pkg::TAG_RIFF) begin
                        phase_in   = PH_HALT;
                        push       = 1'b1;
                        cmd.status = wcp_pkg::ST_BAD_TAG;
                     end else begin
                        phase_in = PH_RSIZE;
                     end
                  end
                  PH_RSIZE: phase_in = PH_WAVE;
                  PH_WAVE: begin
                     if (tag_in != wcp_pkg::TAG_WAVE) begin
                        phase_in   = PH_HALT;
                        push       = 1'b1;
                        cmd.status = wcp_pkg::ST_BAD_TAG;
                     end else begin
                        phase_in = PH_ID;
                     end
                  end
                  default: phase_in = PH_LEN;
               endcase
            end
         end
         PH_LEN: begin
            len_in   = {file_byte, c_len[31:8]};
            count_in = c_count + 5'd1;
            if (c_count == 5'd3) begin
               count_in = '0;
               left_in  = len_in;
               if (c_tag == wcp_pkg::TAG_FMT && !c_seen) begin
                  if (len_in < wcp_pkg::FMT_BODY) begin
                     phase_in   = PH_HALT;
                     push       = 1'b1;
                     cmd.status = wcp_pkg::ST_BAD_FMT;
                  end else begin
                     phase_in = PH_FMT;
                  end
               end else if (c_tag == wcp_pkg::TAG_DATA) begin
                  if (!c_seen) begin
                     phase_in   = PH_HALT;
                     push       = 1'b1;
                     cmd.status = wcp_pkg::ST_NO_FMT;
                  end else begin
                     pos_in   = '0;
                     phase_in = (len_in == '0) ? PH_ID : PH_DATA;
                  end
               end else begin
                  phase_in = (len_in == '0) ? PH_ID : PH_SKIP;
               end
            end
         end
         PH_FMT: begin
            case (c_count[3:0])
               4'd0:    code_in[7:0]   = file_byte;
               4'd1:    code_in[15:8]  = file_byte;
               4'd2:    chan_in[7:0]   = file_byte;
               4'd3:    chan_in[15:8]  = file_byte;
               4'd4:    rate_in[7:0]   = file_byte;
               4'd5:    rate_in[15:8]  = file_byte;
               4'd6:    rate_in[23:16] = file_byte;
               4'd7:    rate_in[31:24] = file_byte;
               4'd14:   bits_in[7:0]   = file_byte;
               4'd15:   bits_in[15:8]  = file_byte;
               default: ;
            endcase
            left_in  = c_left - 32'd1;
            count_in = c_count + 5'd1;
            if (c_count == 5'd15) begin
               count_in  = '0;
               is_stereo = (chan_in == 16'd2);
               is_16     = (bits_in == 16'd16);
               fmt_ok    = (code_in == 16'd1) && (chan_in == 16'd1 || is_stereo)
                           && (bits_in == 16'd8 || is_16);
               if (!fmt_ok) begin
                  phase_in   = PH_HALT;
                  push       = 1'b1;
                  cmd.status = wcp_pkg::ST_BAD_FMT;
               end else begin
                  // block size is 1, 2 or 4 bytes
                  bb_in   = {is_stereo & is_16, is_stereo ^ is_16, ~is_stereo & ~is_16};
                  seen_in = 1'b1;
                  if (left_in != '0) begin
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = c_len[0] ? PH_PAD : PH_ID;
                  end
                  push            = 1'b1;
                  cmd.status      = wcp_pkg::ST_FMT_OK;
                  cmd.sample_type = {is_stereo, is_16};
                  cmd.frame_rate  = rate_in;
               end
            end
         end
         PH_SKIP: begin
            left_in = c_left - 32'd1;
            if (left_in == '0) begin
               count_in = '0;
               phase_in = c_len[0] ? PH_PAD : PH_ID;
            end
         end
         PH_DATA: begin
            left_in = c_left - 32'd1;
            // bytes of the trailing partial block give no result
            if (c_left > {30'd0, rem}) begin
               last            = (c_pos == bb_mask);
               pos_in          = last ? 2'd0 : c_pos + 2'd1;
               push            = 1'b1;
               cmd.status      = wcp_pkg::ST_SAMPLE;
               cmd.sample_byte = file_byte;
               cmd.block_last  = last;
            end
            if (left_in == '0) begin
               count_in = '0;
               phase_in = c_len[0] ? PH_PAD : PH_ID;
            end
         end
         PH_PAD: begin
            phase_in = PH_ID;
            count_in = '0;
         end
         default: ;
      endcase

      if (!accept) begin
         push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_RIFF;
         count_ff <= '0;
         tag_ff   <= '0;
         len_ff   <= '0;
         left_ff  <= '0;
         code_ff  <= '0;
         chan_ff  <= '0;
         rate_ff  <= '0;
         bits_ff  <= '0;
         bb_ff    <= '0;
         pos_ff   <= '0;
         seen_ff  <= 1'b0;
      end else if (accept) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         tag_ff   <= tag_in;
         len_ff   <= len_in;
         left_ff  <= left_in;
         code_ff  <= code_in;
         chan_ff  <= chan_in;
         rate_ff  <= rate_in;
         bits_ff  <= bits_in;
         bb_ff    <= bb_in;
         pos_ff   <= pos_in;
         seen_ff  <= seen_in;
      end
   end

endmodule

// File: src/wcp_queue.sv
// ----------------------------------------------------------------------------
// wcp_queue
// Two-entry command queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module wcp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  wcp_pkg::wcp_cmd_type  push_cmd,
   input  logic                  pop,
   output wcp_pkg::wcp_cmd_type  head_cmd,
   output wcp_pkg::wcp_qstat_type stat
);

   localparam int PTR_W = $clog2(wcp_pkg::QUEUE_DEPTH);
   localparam int CNT_W = $clog2(wcp_pkg::QUEUE_DEPTH + 1);

   wcp_pkg::wcp_cmd_type entry_ff [wcp_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(wcp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(wcp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   assign head_cmd       = entry_ff[rd_ff];
   assign stat.full      = (cnt_ff == CNT_W'(wcp_pkg::QUEUE_DEPTH));
   assign stat.not_empty = (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/wcp_back.sv
// ----------------------------------------------------------------------------
// wcp_back
// Output stage: holds the accepted format and builds the result fields into
// the response register.
// ----------------------------------------------------------------------------
module wcp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  wcp_pkg::wcp_cmd_type cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [2:0]           rsp_status,
   output logic [7:0]           rsp_sample_byte,
   output logic [1:0]           rsp_sample_type,
   output logic [31:0]          rsp_frame_rate,
   output logic                 rsp_block_last
);

   logic        valid_ff, valid_in;
   logic        load;
   logic [1:0]  type_ff, type_in;
   logic [31:0] rate_ff, rate_in;
   wcp_pkg::wcp_cmd_type out_ff, out_in;

   assign load = !valid_ff || !rsp_stall;
   assign pop  = cmd_valid && load;

   always_comb begin
      valid_in = valid_ff;
      type_in  = type_ff;
      rate_in  = rate_ff;
      out_in   = cmd;
      if (load) begin
         valid_in = cmd_valid;
      end
      case (cmd.status)
         wcp_pkg::ST_FMT_OK: begin
            type_in = cmd.sample_type;
            rate_in = cmd.frame_rate;
         end
         wcp_pkg::ST_SAMPLE: begin
            // samples carry the format that was last accepted
            out_in.sample_type = type_ff;
            out_in.frame_rate  = rate_ff;
         end
         default: ;
      endcase
      if (!pop) begin
         type_in = type_ff;
         rate_in = rate_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         type_ff  <= '0;
         rate_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         type_ff  <= type_in;
         rate_ff  <= rate_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_status      = out_ff.status;
   assign rsp_sample_byte = out_ff.sample_byte;
   assign rsp_sample_type = out_ff.sample_type;
   assign rsp_frame_rate  = out_ff.frame_rate;
   assign rsp_block_last  = out_ff.block_last;

endmodule

// File: src/wav_chunk_parser.sv
// ----------------------------------------------------------------------------
// wav_chunk_parser
// RIFF/WAVE PCM stream parser: file bytes in, sample bytes and status out.
// ----------------------------------------------------------------------------
// The req_ channel carries one file byte per transfer; req_restart marks the
// first byte of a new file and clears the parse state before that byte.
// The rsp_ channel carries zero or one result per byte: a sample byte with
// its block_last mark, a format report, or an error code. After an error no
// result follows until the next restart.
// Throughput is one byte per cycle while req_stall is low. A result reaches
// rsp_ by way of a command queue, which the parser writes at the byte's transfer
// edge, and then the response register, which the output stage loads from it.
// The two-entry queue sets req_stall: it rises only when the queue is full,
// so a stall on rsp_ reaches the input once the response register and both
// queue entries hold results.
// Bytes that give no result never wait on the queue's drain beyond that.
// Reset empties the queue and the response register and returns the parser
// to the RIFF tag; rsp_valid is low in the cycle after reset.
// While rsp_stall is high the response register holds its result.
// ----------------------------------------------------------------------------
module wav_chunk_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_file_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_sample_byte,
   output logic [1:0]  rsp_sample_type,
   output logic [31:0] rsp_frame_rate,
   output logic        rsp_block_last
);

   logic                   accept;
   logic                   push;
   logic                   pop;
   wcp_pkg::wcp_cmd_type   push_cmd;
   wcp_pkg::wcp_cmd_type   head_cmd;
   wcp_pkg::wcp_qstat_type q_stat;

   assign req_stall = q_stat.full;
   assign accept    = req_valid && !req_stall;

   wcp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .file_byte (req_file_byte),
      .restart   (req_restart),
      .push      (push),
      .cmd       (push_cmd)
   );

   wcp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (q_stat)
   );

   wcp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cmd_valid       (q_stat.not_empty),
      .cmd             (head_cmd),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_sample_byte (rsp_sample_byte),
      .rsp_sample_type (rsp_sample_type),
      .rsp_frame_rate  (rsp_frame_rate),
      .rsp_block_last  (rsp_block_last)
   );

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_stat.full |-> !push)
      else $error("command pushed into a full queue");

   a_error_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == wcp_pkg::ST_BAD_TAG || rsp_status == wcp_pkg::ST_BAD_FMT
                    || rsp_status == wcp_pkg::ST_NO_FMT)
      |-> rsp_frame_rate == '0 && rsp_sample_type == '0)
      else $error("error result carries format fields");

   a_non_sample_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != wcp_pkg::ST_SAMPLE |-> !rsp_block_last && rsp_sample_byte == '0)
      else $error("non-sample result carries sample fields");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !q_stat.not_empty)
      else $error("results pending after reset");

endmodule

// File: test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for wav_chunk_parser. WAV files are built chunk by chunk
// from a row table: tags, chunk headers, fmt chunks and plain chunks. The
// bytes are streamed through the req_ channel and every rsp_ transfer is
// checked field by field against a byte-level model of the parser. Rows with
// an obvious outcome (tag errors, fmt errors, format reports) carry their own
// expected result. A short directed table comes first, then random files in
// four traffic phases with different sender idle and receiver stall rates.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_LEN, PH_FMT, PH_SKIP, PH_DATA, PH_PAD, PH_HALT
   } parse_phase_type;

   typedef enum logic [2:0] {ROW_WORD, ROW_FILE, ROW_HDR, ROW_FMT, ROW_CHUNK} row_kind_type;

   typedef struct {
      row_kind_type kind;
      logic        restart;
      logic [31:0] tag;
      logic [31:0] len;
      logic [15:0] code;
      logic [15:0] chans;
      logic [15:0] bits;
      logic [31:0] rate;
      logic        typed;
      logic [2:0]  exp_status;
      logic [1:0]  exp_sample_type;
      logic [31:0] exp_rate;
   } file_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_file_byte = 8'd0;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_sample_byte;
   logic [1:0]  rsp_sample_type;
   logic [31:0] rsp_frame_rate;
   logic        rsp_block_last;

   // parser model state
   parse_phase_type m_phase;
   logic [4:0]   m_count;
   logic [31:0]  m_tag;
   logic [31:0]  m_len;
   logic [31:0]  m_left;
   logic [15:0]  m_code;
   logic [15:0]  m_chans;
   logic [31:0]  m_rate;
   logic [15:0]  m_blk_bytes;
   logic [15:0]  m_bits;
   logic [15:0]  m_blk_pos;
   logic         m_fmt_seen;

   wcp_pkg::wcp_cmd_type results_q[$];
   wcp_pkg::wcp_cmd_type head;
   file_row_type row_q[$];
   logic [7:0]  file_bytes[$];
   bit          typed_row = 1'b0;
   int          mismatch_count = 0;
   int          items_sent = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          idle_by_phase[4] = '{0, 76, 0, 6};
   int          stall_by_phase[4] = '{0, 0, 76, 6};
   int          target;

   wav_chunk_parser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_file_byte   (req_file_byte),
      .req_restart     (req_restart),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_sample_byte (rsp_sample_byte),
      .rsp_sample_type (rsp_sample_type),
      .rsp_frame_rate  (rsp_frame_rate),
      .rsp_block_last  (rsp_block_last)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // ---------------- parser model ----------------

   function automatic void clear_parser();
      m_phase = PH_RIFF;
      m_count = '0;
      m_tag = '0;
      m_len = '0;
      m_left = '0;
      m_code = '0;
      m_chans = '0;
      m_rate = '0;
      m_blk_bytes = '0;
      m_bits = '0;
      m_blk_pos = '0;
      m_fmt_seen = 1'b0;
   endfunction

   function automatic void post_result(logic [2:0] st, logic [7:0] b, logic last);
      wcp_pkg::wcp_cmd_type r;
      r.status = st;
      r.sample_byte = b;
      r.block_last = last;
      r.sample_type = (st <= wcp_pkg::ST_FMT_OK) ? {m_chans == 16'd2, m_bits == 16'd16} : 2'd0;
      r.frame_rate = (st <= wcp_pkg::ST_FMT_OK) ? m_rate : 32'd0;
      // a row with a typed-in expectation has already queued its result
      if (!typed_row)
         results_q.push_back(r);
   endfunction

   function automatic void halt_with(logic [2:0] st);
      m_phase = PH_HALT;
      post_result(st, 8'd0, 1'b0);
   endfunction

   function automatic void end_body();
      m_count = '0;
      m_phase = m_len[0] ? PH_PAD : PH_ID;
   endfunction

   function automatic void parse_file_byte(logic [7:0] b, logic r);
      logic [31:0] whole;
      logic [31:0] used;
      logic        last;
      if (r)
         clear_parser();
      case (m_phase)
         PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID: begin
            m_tag = {b, m_tag[31:8]};
            m_count = m_count + 5'd1;
            if (m_count == 5'd4) begin
               m_count = '0;
               case (m_phase)
                  PH_RIFF: begin
                     if (m_tag != wcp_pkg::TAG_RIFF) halt_with(wcp_pkg::ST_BAD_TAG);
                     else m_phase = PH_RSIZE;
                  end
                  PH_RSIZE: m_phase = PH_WAVE;
                  PH_WAVE: begin
                     if (m_tag != wcp_pkg::TAG_WAVE) halt_with(wcp_pkg::ST_BAD_TAG);
                     else m_phase = PH_ID;
                  end
                  default: m_phase = PH_LEN;
               endcase
            end
         end
         PH_LEN: begin
            m_len = {b, m_len[31:8]};
            m_count = m_count + 5'd1;
            if (m_count == 5'd4) begin
               m_count = '0;
               m_left = m_len;
               if (m_tag == wcp_pkg::TAG_FMT && !m_fmt_seen) begin
                  if (m_len < wcp_pkg::FMT_BODY) halt_with(wcp_pkg::ST_BAD_FMT);
                  else m_phase = PH_FMT;
               end else if (m_tag == wcp_pkg::TAG_DATA) begin
                  if (!m_fmt_seen) begin
                     halt_with(wcp_pkg::ST_NO_FMT);
                  end else begin
                     m_blk_pos = '0;
                     if (m_len == 0) end_body();
                     else m_phase = PH_DATA;
                  end
               end else if (m_len == 0) begin
                  end_body();
               end else begin
                  m_phase = PH_SKIP;
               end
            end
         end
         PH_FMT: begin
            if (m_count < 2)
               m_code = m_code | (16'(b) << (8 * m_count));
            else if (m_count < 4)
               m_chans = m_chans | (16'(b) << (8 * (m_count - 2)));
            else if (m_count < 8)
               m_rate = m_rate | (32'(b) << (8 * (m_count - 4)));
            else if (m_count >= 14)
               m_bits = m_bits | (16'(b) << (8 * (m_count - 14)));
            m_count = m_count + 5'd1;
            m_left = m_left - 32'd1;
            if (m_count == 5'd16) begin
               m_count = '0;
               if (m_code != 16'd1 || (m_chans != 16'd1 && m_chans != 16'd2) ||
                   (m_bits != 16'd8 && m_bits != 16'd16)) begin
                  m_rate = '0;
                  m_chans = '0;
                  m_bits = '0;
                  halt_with(wcp_pkg::ST_BAD_FMT);
               end else begin
                  m_blk_bytes = m_chans * (m_bits / 16'd8);
                  m_fmt_seen = 1'b1;
                  if (m_left != 0) m_phase = PH_SKIP;
                  else end_body();
                  post_result(wcp_pkg::ST_FMT_OK, 8'd0, 1'b0);
               end
            end
         end
         PH_SKIP: begin
            m_left = m_left - 32'd1;
            if (m_left == 0)
               end_body();
         end
         PH_DATA: begin
            // only whole blocks go out, the tail of a partial block is dropped
            whole = m_len & ~(32'(m_blk_bytes) - 32'd1);
            used = m_len - m_left;
            m_left = m_left - 32'd1;
            if (used < whole) begin
               last = (m_blk_pos == m_blk_bytes - 16'd1);
               m_blk_pos = last ? 16'd0 : m_blk_pos + 16'd1;
               post_result(wcp_pkg::ST_SAMPLE, b, last);
            end
            if (m_left == 0)
               end_body();
         end
         PH_PAD: begin
            m_phase = PH_ID;
            m_count = '0;
         end
         default: ;
      endcase
   endfunction

   // ---------------- stimulus ----------------

   function automatic void add_row(row_kind_type kind, logic rst, logic [31:0] tag,
         logic [31:0] len, logic [15:0] code = 16'd0, logic [15:0] chans = 16'd0,
         logic [15:0] bits = 16'd0, logic [31:0] rate = 32'd0);
      file_row_type rw;
      rw.kind = kind;
      rw.restart = rst;
      rw.tag = tag;
      rw.len = len;
      rw.code = code;
      rw.chans = chans;
      rw.bits = bits;
      rw.rate = rate;
      rw.typed = 1'b0;
      rw.exp_status = '0;
      rw.exp_sample_type = '0;
      rw.exp_rate = '0;
      row_q.push_back(rw);
   endfunction

   function automatic void expect_result(logic [2:0] st, logic [1:0] ty, logic [31:0] rt);
      int last_row;
      last_row = row_q.size() - 1;
      row_q[last_row].typed = 1'b1;
      row_q[last_row].exp_status = st;
      row_q[last_row].exp_sample_type = ty;
      row_q[last_row].exp_rate = rt;
   endfunction

   function automatic void push_le(logic [31:0] v, int n);
      for (int k = 0; k < n; k++)
         file_bytes.push_back(v[8*k +: 8]);
   endfunction

   task automatic send_byte(logic [7:0] b, logic r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_file_byte <= b;
      req_restart <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      parse_file_byte(b, r);
   endtask

   task automatic play_rows();
      wcp_pkg::wcp_cmd_type want;
      foreach (row_q[i]) begin
         file_bytes.delete();
         case (row_q[i].kind)
            ROW_WORD: push_le(row_q[i].tag, 4);
            ROW_FILE: begin
               push_le(wcp_pkg::TAG_RIFF, 4);
               push_le($urandom, 4);
               push_le(row_q[i].tag, 4);
            end
            default: begin
               push_le(row_q[i].tag, 4);
               push_le(row_q[i].len, 4);
            end
         endcase
         if (row_q[i].kind == ROW_FMT) begin
            push_le(row_q[i].code, 2);
            push_le(row_q[i].chans, 2);
            push_le(row_q[i].rate, 4);
            // byte rate and block align are don't-care
            push_le($urandom, 4);
            push_le($urandom, 2);
            push_le(row_q[i].bits, 2);
            repeat (row_q[i].len - 16) push_le($urandom, 1);
            if (row_q[i].len[0]) push_le($urandom, 1);
         end else if (row_q[i].kind == ROW_CHUNK) begin
            repeat (row_q[i].len) push_le($urandom, 1);
            if (row_q[i].len[0]) push_le($urandom, 1);
         end
         typed_row = row_q[i].typed;
         if (typed_row) begin
            want = '0;
            want.status = row_q[i].exp_status;
            want.sample_type = row_q[i].exp_sample_type;
            want.frame_rate = row_q[i].exp_rate;
            results_q.push_back(want);
         end
         foreach (file_bytes[j])
            send_byte(file_bytes[j], row_q[i].restart && j == 0);
      end
      typed_row = 1'b0;
      row_q.delete();
   endtask

   task automatic build_random_file();
      int pick;
      pick = $urandom_range(99);
      if (pick < 4) begin
         // broken file: random first word, then noise
         add_row(ROW_WORD, 1'b1, $urandom, 0);
         add_row(ROW_WORD, 1'b0, $urandom, 0);
         return;
      end
      add_row(ROW_FILE, 1'b1, (pick < 8) ? 32'($urandom) : wcp_pkg::TAG_WAVE, 0);
      repeat ($urandom_range(2)) add_row(ROW_CHUNK, 1'b0, $urandom, $urandom_range(9));
      pick = $urandom_range(99);
      if (pick < 5)
         add_row(ROW_CHUNK, 1'b0, wcp_pkg::TAG_DATA, $urandom_range(8));
      else if (pick < 9)
         add_row(ROW_HDR, 1'b0, wcp_pkg::TAG_FMT, $urandom_range(15));
      else if (pick < 18)
         add_row(ROW_FMT, 1'b0, wcp_pkg::TAG_FMT, 16 + $urandom_range(3),
                 $urandom_range(1) ? 16'd1 : 16'($urandom), 16'($urandom_range(3)),
                 $urandom_range(1) ? 16'($urandom_range(3) * 8) : 16'($urandom), $urandom);
      else
         add_row(ROW_FMT, 1'b0, wcp_pkg::TAG_FMT,
                 16 + (($urandom_range(3) == 0) ? $urandom_range(5) : 0),
                 16'd1, 16'(1 + $urandom_range(1)), 16'(8 * (1 + $urandom_range(1))),
                 $urandom);
      repeat (1 + $urandom_range(4)) begin
         pick = $urandom_range(99);
         if (pick < 70)
            add_row(ROW_CHUNK, 1'b0, wcp_pkg::TAG_DATA,
                    ($urandom_range(9) == 0) ? $urandom_range(64) : $urandom_range(24));
         else if (pick < 85)
            add_row(ROW_CHUNK, 1'b0, $urandom, $urandom_range(12));
         else if (pick < 93)
            add_row(ROW_FMT, 1'b0, wcp_pkg::TAG_FMT, 16 + $urandom_range(4),
                    16'($urandom), 16'($urandom), 16'($urandom), $urandom);
         else
            add_row(ROW_WORD, 1'b0, $urandom, 0);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_q.size() != 0);
   endtask

   // ---------------- result check ----------------

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (results_q.size() == 0) begin
            report_mismatch("unexpected result, status", rsp_status, 0);
         end else begin
            head = results_q.pop_front();
            if (rsp_status !== head.status)
               report_mismatch("status", rsp_status, head.status);
            if (rsp_sample_byte !== head.sample_byte)
               report_mismatch("sample_byte", rsp_sample_byte, head.sample_byte);
            if (rsp_sample_type !== head.sample_type)
               report_mismatch("sample_type", rsp_sample_type, head.sample_type);
            if (rsp_frame_rate !== head.frame_rate)
               report_mismatch("frame_rate", rsp_frame_rate, head.frame_rate);
            if (rsp_block_last !== head.block_last)
               report_mismatch("block_last", rsp_block_last, head.block_last);
         end
      end
   end

   initial begin
      #2_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      clear_parser();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // bad RIFF tag, then a chunk that is ignored while halted
      add_row(ROW_WORD, 1'b1, 32'h5846_4952, 0);           // "RIFX"
      expect_result(wcp_pkg::ST_BAD_TAG, 2'd0, 32'd0);
      add_row(ROW_CHUNK, 1'b0, wcp_pkg::TAG_DATA, 3);
      add_row(ROW_FILE, 1'b1, 32'h5856_4157, 0);           // "WAVX"
      expect_result(wcp_pkg::ST_BAD_TAG, 2'd0, 32'd0);
      add_row(ROW_FILE, 1'b1, wcp_pkg::TAG_WAVE, 0);
      add_row(ROW_HDR, 1'b0, wcp_pkg::TAG_DATA, 8);
      expect_result(wcp_pkg::ST_NO_FMT, 2'd0, 32'd0);
      add_row(ROW_FILE, 1'b1, wcp_pkg::TAG_WAVE, 0);
      add_row(ROW_HDR, 1'b0, wcp_pkg::TAG_FMT, 15);
      expect_result(wcp_pkg::ST_BAD_FMT, 2'd0, 32'd0);
      add_row(ROW_FILE, 1'b1, wcp_pkg::TAG_WAVE, 0);
      add_row(ROW_FMT, 1'b0, wcp_pkg::TAG_FMT, 16, 16'hFFFF, 1, 8, 8000);
      expect_result(wcp_pkg::ST_BAD_FMT, 2'd0, 32'd0);
      add_row(ROW_FILE, 1'b1, wcp_pkg::TAG_WAVE, 0);
      add_row(ROW_FMT, 1'b0, wcp_pkg::TAG_FMT, 16, 1, 3, 16, 8000);
      expect_result(wcp_pkg::ST_BAD_FMT, 2'd0, 32'd0);
      add_row(ROW_FILE, 1'b1, wcp_pkg::TAG_WAVE, 0);
      add_row(ROW_FMT, 1'b0, wcp_pkg::TAG_FMT, 16, 1, 2, 12, 8000);
      expect_result(wcp_pkg::ST_BAD_FMT, 2'd0, 32'd0);
      // mono8 at rate zero behind an odd and an empty chunk, second fmt skipped
      add_row(ROW_FILE, 1'b1, wcp_pkg::TAG_WAVE, 0);
      add_row(ROW_CHUNK, 1'b0, 32'h5453_494C, 5);          // "LIST"
      add_row(ROW_CHUNK, 1'b0, 32'h6B6E_756A, 0);          // "junk"
      add_row(ROW_FMT, 1'b0, wcp_pkg::TAG_FMT, 16, 1, 1, 8, 0);
      expect_result(wcp_pkg::ST_FMT_OK, 2'd0, 32'd0);
      add_row(ROW_CHUNK, 1'b0, wcp_pkg::TAG_DATA, 5);
      add_row(ROW_FMT, 1'b0, wcp_pkg::TAG_FMT, 18, 7, 1, 8, 1);
      add_row(ROW_CHUNK, 1'b0, wcp_pkg::TAG_DATA, 0);
      add_row(ROW_CHUNK, 1'b0, wcp_pkg::TAG_DATA, 4);
      // stereo16 at full-scale rate with fmt extension, partial blocks
      add_row(ROW_FILE, 1'b1, wcp_pkg::TAG_WAVE, 0);
      add_row(ROW_FMT, 1'b0, wcp_pkg::TAG_FMT, 20, 1, 2, 16, 32'hFFFF_FFFF);
      expect_result(wcp_pkg::ST_FMT_OK, 2'd3, 32'hFFFF_FFFF);
      add_row(ROW_CHUNK, 1'b0, wcp_pkg::TAG_DATA, 11);
      add_row(ROW_CHUNK, 1'b0, wcp_pkg::TAG_DATA, 3);
      add_row(ROW_FILE, 1'b1, wcp_pkg::TAG_WAVE, 0);
      add_row(ROW_FMT, 1'b0, wcp_pkg::TAG_FMT, 16, 1, 1, 16, 44100);
      expect_result(wcp_pkg::ST_FMT_OK, 2'd1, 32'd44100);
      add_row(ROW_CHUNK, 1'b0, wcp_pkg::TAG_DATA, 7);
      add_row(ROW_FILE, 1'b1, wcp_pkg::TAG_WAVE, 0);
      add_row(ROW_FMT, 1'b0, wcp_pkg::TAG_FMT, 17, 1, 2, 8, 8000);
      expect_result(wcp_pkg::ST_FMT_OK, 2'd2, 32'd8000);
      // restart arrives in the middle of a data chunk
      add_row(ROW_HDR, 1'b0, wcp_pkg::TAG_DATA, 40);
      add_row(ROW_WORD, 1'b0, $urandom, 0);
      play_rows();
      drain_results();

      for (int p = 0; p < 4; p++) begin
         idle_pct = idle_by_phase[p];
         stall_pct = stall_by_phase[p];
         target = items_sent + 340;
         while (items_sent < target) begin
            build_random_file();
            play_rows();
         end
         // sender holds off until the pipeline is empty
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
